[sv/u8nf_pkg.sv]
// Shared types, codes and the character folding table for the UTF-8 name validator.
// No dependencies; every other file imports this package.
package u8nf_pkg;

    // Verdict codes carried on the last result of a name
    localparam logic [2:0] FR_OK       = 3'd0;
    localparam logic [2:0] FR_UTF8     = 3'd1;
    localparam logic [2:0] FR_CHAR     = 3'd2;
    localparam logic [2:0] FR_BYTES    = 3'd3;
    localparam logic [2:0] FR_CHARS    = 3'd4;
    localparam logic [2:0] FR_NOLETTER = 3'd5;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 8;
    localparam logic [7:0]  REG_MAX_BYTES = 8'd0;
    localparam logic [7:0]  REG_MAX_CHARS = 8'd1;
    localparam logic [7:0]  MAX_BYTES_RST = 8'd192;
    localparam logic [7:0]  MAX_CHARS_RST = 8'd48;

    // ASCII characters the folder produces
    localparam logic [6:0] CH_NONE  = 7'h00;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_APOS  = 7'h27;
    localparam logic [6:0] CH_HYPH  = 7'h2D;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_A     = 7'h41;
    localparam logic [6:0] CH_D     = 7'h44;
    localparam logic [6:0] CH_E     = 7'h45;
    localparam logic [6:0] CH_I     = 7'h49;
    localparam logic [6:0] CH_O     = 7'h4F;
    localparam logic [6:0] CH_U     = 7'h55;
    localparam logic [6:0] CH_Y     = 7'h59;
    localparam logic [6:0] CH_Z     = 7'h5A;
    localparam logic [6:0] CH_LA    = 7'h61;
    localparam logic [6:0] CH_LZ    = 7'h7A;
    localparam logic [6:0] CASE_OFS = 7'h20;

    // Queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic       char_valid;
        logic [6:0] out_char;
        logic       name_done;
        logic [2:0] fail_reason;
    } result_t;

    // One accepted byte's worth of output: an optional held space, then the result
    typedef struct packed {
        logic    space_first;
        result_t res;
    } qentry_t;

    function automatic logic [6:0] fold_char(input logic [20:0] cp);
        logic [20:0] lo;
        logic [6:0]  r;
        lo = cp | 21'h20;
        r  = CH_NONE;
        if (cp < 21'h80) begin
            if (cp[6:0] >= CH_LA && cp[6:0] <= CH_LZ) begin
                r = cp[6:0] - CASE_OFS;
            end else if (cp[6:0] >= CH_A && cp[6:0] <= CH_Z) begin
                r = cp[6:0];
            end else if (cp[6:0] == CH_SPACE || cp[6:0] == CH_HYPH ||
                         cp[6:0] == CH_APOS || cp[6:0] == CH_DOT) begin
                r = cp[6:0];
            end
        end else if (cp >= 21'hC0 && cp <= 21'hFF) begin
            // Latin-1: fold case by forcing the lower-case bit
            if (lo >= 21'hE0 && lo <= 21'hE3)      r = CH_A;
            else if (lo >= 21'hE8 && lo <= 21'hEA) r = CH_E;
            else if (lo == 21'hEC || lo == 21'hED) r = CH_I;
            else if (lo >= 21'hF2 && lo <= 21'hF5) r = CH_O;
            else if (lo == 21'hF9 || lo == 21'hFA) r = CH_U;
            else if (lo == 21'hFD)                 r = CH_Y;
        end else if (cp == 21'h102 || cp == 21'h103) begin
            r = CH_A;
        end else if (cp == 21'h110 || cp == 21'h111) begin
            r = CH_D;
        end else if (cp == 21'h128 || cp == 21'h129) begin
            r = CH_I;
        end else if (cp == 21'h1A0 || cp == 21'h1A1) begin
            r = CH_O;
        end else if (cp == 21'h168 || cp == 21'h169 || cp == 21'h1AF || cp == 21'h1B0) begin
            r = CH_U;
        end else if (cp >= 21'h1EA0 && cp <= 21'h1EB7) begin
            r = CH_A;
        end else if (cp >= 21'h1EB8 && cp <= 21'h1EC7) begin
            r = CH_E;
        end else if (cp >= 21'h1EC8 && cp <= 21'h1ECB) begin
            r = CH_I;
        end else if (cp >= 21'h1ECC && cp <= 21'h1EE3) begin
            r = CH_O;
        end else if (cp >= 21'h1EE4 && cp <= 21'h1EF1) begin
            r = CH_U;
        end else if (cp >= 21'h1EF2 && cp <= 21'h1EF9) begin
            r = CH_Y;
        end
        return r;
    endfunction

endpackage

[sv/utf8_name_fold_validator_top.sv]
// Top level of the UTF-8 name validator with folding to upper-case ASCII.
// Depends on u8nf_pkg, u8nf_front, u8nf_queue and u8nf_back.
//
//  Channel   Direction  Handshake             Contents
//  s_        in         s_tvalid/s_tready     name byte, tlast = last byte of name
//  m_        out        m_tvalid/m_tready     folded char, verdict, tlast = name done
//  cfg_      in         cfg_valid/cfg_ready   register index and 8-bit value
//
// One byte is accepted per cycle while the four-entry queue has room; a byte that
// releases a held space yields two results, which the back end sends one after the other.
// After its byte is accepted, a result is registered first in a queue slot and then in the output register.
// Reset is synchronous and active low; limits return to 192 bytes and 48 characters.
// A stalled m_ side fills the queue, after which s_tready drops until an entry drains.
module utf8_name_fold_validator_top import u8nf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] name_byte
    input  logic                 s_tlast,   // final_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [6:0] out_char, [7] name_ok, [10:8] fail_reason
    output logic                 m_tlast,   // name_done
    output logic                 m_tuser,   // [0] char_valid
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    logic    byte_accept;
    logic    push, pop, empty, full;
    qentry_t push_entry, head_entry;
    result_t out_res;

    assign s_tready    = !full;
    assign byte_accept = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;

    u8nf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .name_byte   (s_tdata),
        .final_byte  (s_tlast),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .push_entry  (push_entry)
    );

    u8nf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (empty),
        .full       (full)
    );

    u8nf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .empty      (empty),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_res    (out_res)
    );

    assign m_tdata = {5'd0, out_res.fail_reason,
                      (out_res.name_done && out_res.fail_reason == FR_OK),
                      out_res.out_char};
    assign m_tlast = out_res.name_done;
    assign m_tuser = out_res.char_valid;

endmodule

[sv/u8nf_front.sv]
// Front end: accepts raw bytes, decodes UTF-8, folds, applies limits and builds queue entries.
// Depends on u8nf_pkg.
module u8nf_front import u8nf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_accept,
    input  logic [7:0]           name_byte,
    input  logic                 final_byte,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 push,
    output qentry_t              push_entry
);

    logic [7:0]  max_bytes_reg, max_chars_reg;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  char_count_reg, char_count_next;
    logic [1:0]  remain_reg, remain_next;
    logic [1:0]  seq_len_reg, seq_len_next;
    logic [20:0] partial_reg, partial_next;
    logic [2:0]  error_reg, error_next;
    logic        seen_letter_reg, seen_letter_next;
    logic        after_space_reg, after_space_next;
    logic        space_pend_reg, space_pend_next;

    logic        char_done;
    logic [20:0] code_point;
    logic [6:0]  folded;
    logic        emit_space, emit_char;
    logic [6:0]  emit_value;
    logic        bad_code;

    always_comb begin
        error_next       = error_reg;
        byte_count_next  = byte_count_reg;
        char_count_next  = char_count_reg;
        remain_next      = remain_reg;
        seq_len_next     = seq_len_reg;
        partial_next     = partial_reg;
        seen_letter_next = seen_letter_reg;
        after_space_next = after_space_reg;
        space_pend_next  = space_pend_reg;
        char_done        = 1'b0;
        code_point       = '0;
        folded           = CH_NONE;
        bad_code         = 1'b0;
        emit_space       = 1'b0;
        emit_char        = 1'b0;
        emit_value       = CH_NONE;

        if (error_next == FR_OK && byte_count_reg >= max_bytes_reg) error_next = FR_BYTES;
        if (byte_count_reg != 8'hFF) byte_count_next = byte_count_reg + 8'd1;

        if (error_next == FR_OK) begin
            if (remain_reg == 2'd0) begin
                if (!name_byte[7]) begin
                    char_done  = 1'b1;
                    code_point = {13'd0, name_byte};
                end else if (name_byte[7:5] == 3'b110) begin
                    // reject overlong two-byte leads
                    if (name_byte[4:0] < 5'd2) begin
                        error_next = FR_UTF8;
                    end else begin
                        partial_next = {16'd0, name_byte[4:0]};
                        seq_len_next = 2'd1;
                        remain_next  = 2'd1;
                    end
                end else if (name_byte[7:4] == 4'b1110) begin
                    partial_next = {17'd0, name_byte[3:0]};
                    seq_len_next = 2'd2;
                    remain_next  = 2'd2;
                end else if (name_byte[7:3] == 5'b11110) begin
                    partial_next = {18'd0, name_byte[2:0]};
                    seq_len_next = 2'd3;
                    remain_next  = 2'd3;
                end else begin
                    error_next = FR_UTF8;
                end
            end else if (name_byte[7:6] != 2'b10) begin
                error_next = FR_UTF8;
            end else begin
                partial_next = {partial_reg[14:0], name_byte[5:0]};
                remain_next  = remain_reg - 2'd1;
                bad_code = (seq_len_reg == 2'd2 && partial_next < 21'h800) ||
                           (seq_len_reg == 2'd3 && partial_next < 21'h10000) ||
                           (partial_next > 21'h10FFFF) ||
                           (partial_next >= 21'hD800 && partial_next <= 21'hDFFF);
                if (remain_next == 2'd0) begin
                    if (bad_code) begin
                        error_next = FR_UTF8;
                    end else begin
                        char_done  = 1'b1;
                        code_point = partial_next;
                    end
                end
            end
        end

        if (char_done) begin
            folded = fold_char(code_point);
            if (char_count_reg >= max_chars_reg) error_next = FR_CHARS;
            if (char_count_reg != 8'hFF) char_count_next = char_count_reg + 8'd1;
            if (error_next == FR_OK) begin
                if (folded == CH_NONE) begin
                    error_next = FR_CHAR;
                end else if (folded == CH_SPACE) begin
                    // hold the space until a non-space shows it is not trailing
                    if (!after_space_reg) space_pend_next = 1'b1;
                    after_space_next = 1'b1;
                end else begin
                    emit_space       = space_pend_reg;
                    emit_char        = 1'b1;
                    emit_value       = folded;
                    space_pend_next  = 1'b0;
                    after_space_next = 1'b0;
                    if (folded >= CH_A && folded <= CH_Z) seen_letter_next = 1'b1;
                end
            end
        end

        if (final_byte) begin
            if (error_next == FR_OK && remain_next != 2'd0) error_next = FR_UTF8;
            if (error_next == FR_OK && !seen_letter_next)   error_next = FR_NOLETTER;
        end
    end

    assign push                        = byte_accept && (emit_char || final_byte);
    assign push_entry.space_first      = emit_space;
    assign push_entry.res.char_valid   = emit_char;
    assign push_entry.res.out_char     = emit_value;
    assign push_entry.res.name_done    = final_byte;
    assign push_entry.res.fail_reason  = final_byte ? error_next : FR_OK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RST;
            max_chars_reg <= MAX_CHARS_RST;
        end else if (cfg_write) begin
            if (cfg_index == REG_MAX_BYTES) max_bytes_reg <= cfg_data;
            if (cfg_index == REG_MAX_CHARS) max_chars_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_accept && final_byte)) begin
            byte_count_reg  <= '0;
            char_count_reg  <= '0;
            remain_reg      <= '0;
            seq_len_reg     <= '0;
            partial_reg     <= '0;
            error_reg       <= FR_OK;
            seen_letter_reg <= 1'b0;
            after_space_reg <= 1'b1;
            space_pend_reg  <= 1'b0;
        end else if (byte_accept) begin
            byte_count_reg  <= byte_count_next;
            char_count_reg  <= char_count_next;
            remain_reg      <= remain_next;
            seq_len_reg     <= seq_len_next;
            partial_reg     <= partial_next;
            error_reg       <= error_next;
            seen_letter_reg <= seen_letter_next;
            after_space_reg <= after_space_next;
            space_pend_reg  <= space_pend_next;
        end
    end

endmodule

[sv/u8nf_queue.sv]
// Short queue of per-byte entries between the decoding front and the output back end.
// Depends on u8nf_pkg.
module u8nf_queue import u8nf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  qentry_t push_entry,
    input  logic    pop,
    output qentry_t head_entry,
    output logic    empty,
    output logic    full
);

    qentry_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (QPTR_W+1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[sv/u8nf_back.sv]
// Back end: drains queue entries into the output register, splitting a held space off first.
// Depends on u8nf_pkg.
module u8nf_back import u8nf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  qentry_t head_entry,
    input  logic    empty,
    output logic    pop,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_res
);

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;
    logic    hold_valid_reg, hold_valid_next;
    result_t hold_res_reg, hold_res_next;
    logic    load;
    result_t space_res;

    assign load = !out_valid_reg || out_ready;

    assign space_res.char_valid  = 1'b1;
    assign space_res.out_char    = CH_SPACE;
    assign space_res.name_done   = 1'b0;
    assign space_res.fail_reason = FR_OK;

    always_comb begin
        pop             = 1'b0;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        hold_valid_next = hold_valid_reg;
        hold_res_next   = hold_res_reg;
        if (load) begin
            if (hold_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = hold_res_reg;
                hold_valid_next = 1'b0;
            end else if (!empty) begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head_entry.space_first) begin
                    // send the space now, park the character behind it
                    out_res_next    = space_res;
                    hold_valid_next = 1'b1;
                    hold_res_next   = head_entry.res;
                end else begin
                    out_res_next = head_entry.res;
                end
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        hold_res_reg <= hold_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
